### design/packet_classifier_dual_slot_fifo_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet classifier.
// Each macro expects clk and rst_n in the scope of its use.
// ---------------------------------------------------------------------------
`ifndef PACKET_CLASSIFIER_DUAL_SLOT_FIFO_ASSERT_SVH
`define PACKET_CLASSIFIER_DUAL_SLOT_FIFO_ASSERT_SVH

`ifndef ASSERT_OFF
`define PCDSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PCDSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCDSF_ASSERT_SAME(label, ante, cons, msg)
`define PCDSF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/pcdsf_pkg.sv
// ---------------------------------------------------------------------------
// pcdsf_pkg
// Types, codes and defaults shared by the packet classifier modules.
// ---------------------------------------------------------------------------
package pcdsf_pkg;

  localparam int DEF_RING_SLOTS = 8;
  localparam int DEF_SLOT_BYTES = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IDX_W      = 6;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_CLEAR = 2'd3
  } pcdsf_cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_QUEUED_PD  = 3'd1,
    ST_QUEUED_SYS = 3'd2,
    ST_REJECTED   = 3'd3,
    ST_FULL       = 3'd4,
    ST_EMPTY      = 3'd5
  } pcdsf_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STD_FIRST  = 3'd0,
    REG_MINI_FIRST = 3'd1,
    REG_HDR_SECOND = 3'd2,
    REG_PD_CODE    = 3'd3,
    REG_SYS_CODE   = 3'd4,
    REG_STD_OFF    = 3'd5,
    REG_MINI_OFF   = 3'd6
  } pcdsf_reg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } pcdsf_state_t;

  typedef struct packed {
    logic [7:0] std_first;
    logic [7:0] mini_first;
    logic [7:0] hdr_second;
    logic [7:0] pd_code;
    logic [7:0] sys_code;
    logic [7:0] std_off;
    logic [7:0] mini_off;
  } pcdsf_cfg_t;

endpackage

### design/pcdsf_ram.sv
// ---------------------------------------------------------------------------
// pcdsf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pcdsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pcdsf_cfg_regs.sv
// ---------------------------------------------------------------------------
// pcdsf_cfg_regs
// Configuration register file: header values, type codes and type offsets.
// ---------------------------------------------------------------------------
module pcdsf_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wen,
  input  logic [pcdsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcdsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pcdsf_pkg::pcdsf_cfg_t                cfg
);
  import pcdsf_pkg::*;

  pcdsf_cfg_t cfg_r;
  pcdsf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (pcdsf_reg_idx_t'(cfg_index))
        REG_STD_FIRST:  cfg_nxt.std_first  = cfg_wdata;
        REG_MINI_FIRST: cfg_nxt.mini_first = cfg_wdata;
        REG_HDR_SECOND: cfg_nxt.hdr_second = cfg_wdata;
        REG_PD_CODE:    cfg_nxt.pd_code    = cfg_wdata;
        REG_SYS_CODE:   cfg_nxt.sys_code   = cfg_wdata;
        REG_STD_OFF:    cfg_nxt.std_off    = cfg_wdata;
        REG_MINI_OFF:   cfg_nxt.mini_off   = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{std_first: 8'd0, mini_first: 8'd0, hdr_second: 8'd0, pd_code: 8'd0,
                 sys_code: 8'd1, std_off: 8'd3, mini_off: 8'd2};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/pcdsf_ctrl.sv
// ---------------------------------------------------------------------------
// pcdsf_ctrl
// Command sequencer: header capture, classification, ring pointers,
// memory addressing and the result register.
// ---------------------------------------------------------------------------
module pcdsf_ctrl #(
  parameter int RING_SLOTS = pcdsf_pkg::DEF_RING_SLOTS,
  parameter int SLOT_BYTES = pcdsf_pkg::DEF_SLOT_BYTES
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  pcdsf_pkg::pcdsf_cfg_t                         cfg,
  // input item
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [1:0]                                    in_command,
  input  logic                                          in_ring_select,
  input  logic [7:0]                                    in_data_byte,
  input  logic                                          in_end_of_packet,
  input  logic [pcdsf_pkg::IDX_W-1:0]                   in_byte_index,
  // result item
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [7:0]                                    out_read_data,
  output logic [2:0]                                    out_status,
  output logic                                          out_pd_waiting,
  output logic                                          out_sys_waiting,
  // slot byte stores
  output logic                                          byte_we,
  output logic [7:0]                                    byte_wdata,
  output logic [$clog2(RING_SLOTS*SLOT_BYTES)-1:0]      pd_byte_waddr,
  output logic [$clog2(RING_SLOTS*SLOT_BYTES)-1:0]      sys_byte_waddr,
  output logic [$clog2(RING_SLOTS*SLOT_BYTES)-1:0]      pd_byte_raddr,
  output logic [$clog2(RING_SLOTS*SLOT_BYTES)-1:0]      sys_byte_raddr,
  input  logic [7:0]                                    pd_byte_rdata,
  input  logic [7:0]                                    sys_byte_rdata,
  // slot length stores
  output logic                                          pd_len_we,
  output logic                                          sys_len_we,
  output logic [$clog2(SLOT_BYTES+1)-1:0]               len_wdata,
  output logic [$clog2(RING_SLOTS)-1:0]                 pd_len_waddr,
  output logic [$clog2(RING_SLOTS)-1:0]                 sys_len_waddr,
  output logic [$clog2(RING_SLOTS)-1:0]                 pd_len_raddr,
  output logic [$clog2(RING_SLOTS)-1:0]                 sys_len_raddr,
  input  logic [$clog2(SLOT_BYTES+1)-1:0]               pd_len_rdata,
  input  logic [$clog2(SLOT_BYTES+1)-1:0]               sys_len_rdata
);
  import pcdsf_pkg::*;

  localparam int PW = $clog2(RING_SLOTS);
  localparam int CW = $clog2(SLOT_BYTES);
  localparam int LW = $clog2(SLOT_BYTES+1);
  localparam int AW = $clog2(RING_SLOTS*SLOT_BYTES);
  localparam logic [PW-1:0] LAST_SLOT    = PW'(RING_SLOTS-1);
  localparam logic [15:0]   SLOT_BYTES_W = 16'(SLOT_BYTES);
  localparam logic [AW-1:0] SLOT_STRIDE  = AW'(SLOT_BYTES);
  localparam logic [15:0]   CNT_MAX      = 16'hFFFF;

  pcdsf_state_t state_r, state_nxt;

  logic [PW-1:0] pd_wp_r, pd_wp_nxt, pd_rp_r, pd_rp_nxt;
  logic [PW-1:0] sys_wp_r, sys_wp_nxt, sys_rp_r, sys_rp_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic [7:0]    first_r, first_nxt, second_r, second_nxt;
  logic [7:0]    std_cap_r, std_cap_nxt, mini_cap_r, mini_cap_nxt;

  logic          rd_empty_r, rd_idx_ok_r, rd_sel_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  pcdsf_status_t out_status_r, out_status_nxt;
  logic          out_pdw_r, out_pdw_nxt, out_sysw_r, out_sysw_nxt;

  pcdsf_cmd_t    cmd;
  logic          in_fire;
  logic          load;
  logic [15:0]   cnt_inc;
  logic [7:0]    cur_first, cur_second, cur_std_cap, cur_mini_cap, dtype;
  logic          hdr_ok, to_pd, to_sys;
  logic [15:0]   stored;
  pcdsf_status_t fin_status;
  logic [PW-1:0] sel_wp, sel_rp, sel_wp_next;
  logic          sel_has_data;
  logic [LW-1:0] rd_len;
  logic [7:0]    rd_byte;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign cmd      = pcdsf_cmd_t'(in_command);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Capture of the header bytes and both data-type candidates for this byte.
  assign cur_first    = (cnt_r == 16'd0) ? in_data_byte : first_r;
  assign cur_second   = (cnt_r == 16'd1) ? in_data_byte : second_r;
  assign cur_std_cap  = (cnt_r == {8'd0, cfg.std_off}) ? in_data_byte : std_cap_r;
  assign cur_mini_cap = (cnt_r == {8'd0, cfg.mini_off}) ? in_data_byte : mini_cap_r;
  assign cnt_inc      = (cnt_r != CNT_MAX) ? cnt_r + 16'd1 : cnt_r;

  // Header check and routing at the final byte; cnt_inc is the packet length.
  always_comb begin
    hdr_ok = 1'b0;
    dtype  = cur_mini_cap;
    if ((cnt_inc > {8'd0, cfg.mini_off}) && (cur_second == cfg.hdr_second)) begin
      if ((cur_first == cfg.std_first) && (cnt_inc > {8'd0, cfg.std_off})) begin
        hdr_ok = 1'b1;
        dtype  = cur_std_cap;
      end else if (cur_first == cfg.mini_first) begin
        hdr_ok = 1'b1;
      end
    end
    to_pd  = hdr_ok && (dtype == cfg.pd_code);
    to_sys = hdr_ok && !to_pd && (dtype == cfg.sys_code);
    if (!(to_pd || to_sys)) begin
      fin_status = ST_REJECTED;
    end else if (to_pd) begin
      fin_status = (next_slot(pd_wp_r) == pd_rp_r) ? ST_FULL : ST_QUEUED_PD;
    end else begin
      fin_status = (next_slot(sys_wp_r) == sys_rp_r) ? ST_FULL : ST_QUEUED_SYS;
    end
  end

  assign stored = (cnt_inc > SLOT_BYTES_W) ? SLOT_BYTES_W : cnt_inc;

  assign sel_wp       = in_ring_select ? sys_wp_r : pd_wp_r;
  assign sel_rp       = in_ring_select ? sys_rp_r : pd_rp_r;
  assign sel_wp_next  = next_slot(sel_rp);
  assign sel_has_data = (sel_wp != sel_rp);

  // Memory ports. Every byte within the slot size goes into the head slot of both rings.
  assign byte_we        = in_fire && (cmd == CMD_BYTE) && (cnt_r < SLOT_BYTES_W);
  assign byte_wdata     = in_data_byte;
  assign pd_byte_waddr  = AW'(pd_wp_r) * SLOT_STRIDE + AW'(CW'(cnt_r));
  assign sys_byte_waddr = AW'(sys_wp_r) * SLOT_STRIDE + AW'(CW'(cnt_r));
  assign pd_byte_raddr  = AW'(pd_rp_r) * SLOT_STRIDE + AW'(CW'(in_byte_index));
  assign sys_byte_raddr = AW'(sys_rp_r) * SLOT_STRIDE + AW'(CW'(in_byte_index));

  assign pd_len_we     = in_fire && (cmd == CMD_BYTE) && in_end_of_packet &&
                         (fin_status == ST_QUEUED_PD);
  assign sys_len_we    = in_fire && (cmd == CMD_BYTE) && in_end_of_packet &&
                         (fin_status == ST_QUEUED_SYS);
  assign len_wdata     = LW'(stored);
  assign pd_len_waddr  = pd_wp_r;
  assign sys_len_waddr = sys_wp_r;
  assign pd_len_raddr  = pd_rp_r;
  assign sys_len_raddr = sys_rp_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && (cmd == CMD_READ)) state_nxt = S_READ;
      S_READ:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Per-command updates of pointers, packet capture and result.
  always_comb begin
    pd_wp_nxt      = pd_wp_r;
    pd_rp_nxt      = pd_rp_r;
    sys_wp_nxt     = sys_wp_r;
    sys_rp_nxt     = sys_rp_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    std_cap_nxt    = std_cap_r;
    mini_cap_nxt   = mini_cap_r;
    out_status_nxt = ST_OK;
    if (in_fire) begin
      case (cmd)
        CMD_BYTE: begin
          if (in_end_of_packet) begin
            out_status_nxt = fin_status;
            cnt_nxt        = '0;
            first_nxt      = '0;
            second_nxt     = '0;
            std_cap_nxt    = '0;
            mini_cap_nxt   = '0;
            if (fin_status == ST_QUEUED_PD) pd_wp_nxt = next_slot(pd_wp_r);
            if (fin_status == ST_QUEUED_SYS) sys_wp_nxt = next_slot(sys_wp_r);
          end else begin
            cnt_nxt      = cnt_inc;
            first_nxt    = cur_first;
            second_nxt   = cur_second;
            std_cap_nxt  = cur_std_cap;
            mini_cap_nxt = cur_mini_cap;
          end
        end
        CMD_READ: begin
          out_status_nxt = sel_has_data ? ST_OK : ST_EMPTY;
        end
        CMD_POP: begin
          if (!sel_has_data) begin
            out_status_nxt = ST_EMPTY;
          end else if (in_ring_select) begin
            sys_rp_nxt = sel_wp_next;
          end else begin
            pd_rp_nxt = sel_wp_next;
          end
        end
        CMD_CLEAR: begin
          if (in_ring_select) begin
            sys_wp_nxt = '0;
            sys_rp_nxt = '0;
          end else begin
            pd_wp_nxt = '0;
            pd_rp_nxt = '0;
          end
        end
        default: out_status_nxt = ST_OK;
      endcase
    end
  end

  // Result register: loaded at accept, or in the cycle after accept for a byte read.
  assign rd_len  = rd_sel_r ? sys_len_rdata : pd_len_rdata;
  assign rd_byte = rd_sel_r ? sys_byte_rdata : pd_byte_rdata;
  assign load    = (in_fire && (cmd != CMD_READ)) || (state_r == S_READ);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_pdw_nxt   = out_pdw_r;
    out_sysw_nxt  = out_sysw_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_pdw_nxt   = (pd_wp_nxt != pd_rp_nxt);
      out_sysw_nxt  = (sys_wp_nxt != sys_rp_nxt);
      out_data_nxt  = '0;
      if ((state_r == S_READ) && !rd_empty_r && rd_idx_ok_r &&
          (16'(rd_idx_r) < 16'(rd_len))) begin
        out_data_nxt = rd_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pd_wp_r     <= '0;
      pd_rp_r     <= '0;
      sys_wp_r    <= '0;
      sys_rp_r    <= '0;
      cnt_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      std_cap_r   <= '0;
      mini_cap_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pd_wp_r     <= pd_wp_nxt;
      pd_rp_r     <= pd_rp_nxt;
      sys_wp_r    <= sys_wp_nxt;
      sys_rp_r    <= sys_rp_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      std_cap_r   <= std_cap_nxt;
      mini_cap_r  <= mini_cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= (state_r == S_READ) ? (rd_empty_r ? ST_EMPTY : ST_OK) : out_status_nxt;
      out_pdw_r    <= out_pdw_nxt;
      out_sysw_r   <= out_sysw_nxt;
    end
    if (in_fire && (cmd == CMD_READ)) begin
      rd_empty_r  <= (out_status_nxt == ST_EMPTY);
      rd_idx_ok_r <= (16'(in_byte_index) < SLOT_BYTES_W);
      rd_idx_r    <= in_byte_index;
      rd_sel_r    <= in_ring_select;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_status      = out_status_r;
  assign out_pd_waiting  = out_pdw_r;
  assign out_sys_waiting = out_sysw_r;

`include "packet_classifier_dual_slot_fifo_assert.svh"

  `PCDSF_ASSERT_SAME(a_read_slot_free, state_r == S_READ, !out_valid_r, "read result slot busy")
  `PCDSF_ASSERT_NEXT(a_read_enters_wait, in_fire && (cmd == CMD_READ), state_r == S_READ, "no read wait")
  `PCDSF_ASSERT_NEXT(a_read_delivers, state_r == S_READ, out_valid_r, "read result not loaded")
  `PCDSF_ASSERT_SAME(a_queued_pd_waits, out_valid_r && (out_status_r == ST_QUEUED_PD), out_pdw_r, "queued PD but ring empty")
  `PCDSF_ASSERT_SAME(a_queued_sys_waits, out_valid_r && (out_status_r == ST_QUEUED_SYS), out_sysw_r, "queued SYS but ring empty")

endmodule

### design/packet_classifier_dual_slot_fifo.sv
// ---------------------------------------------------------------------------
// packet_classifier_dual_slot_fifo
// Packet classifier queueing packets into PD and SYS rings of fixed slots.
// ---------------------------------------------------------------------------
// Every command is done at accept but a byte read, which waits in S_READ as
// the slot byte and slot length memories have a registered read port; the
// next item is taken when no read waits and the result register is free or
// being drained. Packet bytes within a slot's size go into the head slot of
// both rings at once and the chosen ring's head advances on the last byte.
// The memories need no clearing after reset, so the block is ready at once.
module packet_classifier_dual_slot_fifo #(
  parameter int RING_SLOTS = pcdsf_pkg::DEF_RING_SLOTS,
  parameter int SLOT_BYTES = pcdsf_pkg::DEF_SLOT_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [pcdsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcdsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,  // data_byte[7:0], byte_index[13:8]
  input  logic [2:0]                        in_tuser,  // command[1:0], ring_select[2]
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_data[7:0], status[10:8], pd_waiting[11], sys_waiting[12]
  output logic [15:0]                       out_tdata
);
  import pcdsf_pkg::*;

  localparam int AW = $clog2(RING_SLOTS*SLOT_BYTES);
  localparam int PW = $clog2(RING_SLOTS);
  localparam int LW = $clog2(SLOT_BYTES+1);

  pcdsf_cfg_t    cfg;
  logic          byte_we;
  logic [7:0]    byte_wdata, pd_byte_rdata, sys_byte_rdata;
  logic [AW-1:0] pd_byte_waddr, sys_byte_waddr, pd_byte_raddr, sys_byte_raddr;
  logic          pd_len_we, sys_len_we;
  logic [LW-1:0] len_wdata, pd_len_rdata, sys_len_rdata;
  logic [PW-1:0] pd_len_waddr, sys_len_waddr, pd_len_raddr, sys_len_raddr;
  logic [7:0]    read_data;
  logic [2:0]    status;
  logic          pd_waiting, sys_waiting;

  pcdsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcdsf_ctrl #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_command       (in_tuser[1:0]),
    .in_ring_select   (in_tuser[2]),
    .in_data_byte     (in_tdata[7:0]),
    .in_end_of_packet (in_tlast),
    .in_byte_index    (in_tdata[13:8]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_read_data    (read_data),
    .out_status       (status),
    .out_pd_waiting   (pd_waiting),
    .out_sys_waiting  (sys_waiting),
    .byte_we          (byte_we),
    .byte_wdata       (byte_wdata),
    .pd_byte_waddr    (pd_byte_waddr),
    .sys_byte_waddr   (sys_byte_waddr),
    .pd_byte_raddr    (pd_byte_raddr),
    .sys_byte_raddr   (sys_byte_raddr),
    .pd_byte_rdata    (pd_byte_rdata),
    .sys_byte_rdata   (sys_byte_rdata),
    .pd_len_we        (pd_len_we),
    .sys_len_we       (sys_len_we),
    .len_wdata        (len_wdata),
    .pd_len_waddr     (pd_len_waddr),
    .sys_len_waddr    (sys_len_waddr),
    .pd_len_raddr     (pd_len_raddr),
    .sys_len_raddr    (sys_len_raddr),
    .pd_len_rdata     (pd_len_rdata),
    .sys_len_rdata    (sys_len_rdata)
  );

  pcdsf_ram #(.WIDTH(8), .DEPTH(RING_SLOTS*SLOT_BYTES)) u_pd_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (pd_byte_waddr),
    .wdata (byte_wdata),
    .raddr (pd_byte_raddr),
    .rdata (pd_byte_rdata)
  );

  pcdsf_ram #(.WIDTH(8), .DEPTH(RING_SLOTS*SLOT_BYTES)) u_sys_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (sys_byte_waddr),
    .wdata (byte_wdata),
    .raddr (sys_byte_raddr),
    .rdata (sys_byte_rdata)
  );

  pcdsf_ram #(.WIDTH(LW), .DEPTH(RING_SLOTS)) u_pd_len (
    .clk   (clk),
    .we    (pd_len_we),
    .waddr (pd_len_waddr),
    .wdata (len_wdata),
    .raddr (pd_len_raddr),
    .rdata (pd_len_rdata)
  );

  pcdsf_ram #(.WIDTH(LW), .DEPTH(RING_SLOTS)) u_sys_len (
    .clk   (clk),
    .we    (sys_len_we),
    .waddr (sys_len_waddr),
    .wdata (len_wdata),
    .raddr (sys_len_raddr),
    .rdata (sys_len_rdata)
  );

  assign out_tdata = {3'b000, sys_waiting, pd_waiting, status, read_data};

endmodule
